// ----- sv/lcst_pkg.sv -----
// Shared types and constants for the line-set maximum query tree.
`default_nettype none
package lcst_pkg;

    localparam int DOMAIN_POINTS = 65536;
    localparam int TREE_DEPTH    = 4 * DOMAIN_POINTS;
    localparam int TREE_AW       = $clog2(TREE_DEPTH);
    localparam int REL_W         = $clog2(DOMAIN_POINTS);
    localparam int COORD_W       = 24;
    localparam int ABS_W         = COORD_W + 1;
    localparam int SLOPE_W       = 32;
    localparam int ICPT_W        = 61;
    localparam int VAL_W         = 64;
    localparam int OUT_W         = 63;
    localparam int PROD_W        = SLOPE_W + ABS_W;
    localparam int STACK_DEPTH   = REL_W + 2;
    localparam int STK_AW        = $clog2(STACK_DEPTH);
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);

    // minus 0x3f3f3f3f3f3f3f3f
    localparam logic signed [VAL_W-1:0] NONE_VALUE = 64'shC0C0C0C0C0C0C0C1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    typedef struct packed {
        logic                      valid;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
    } node_t;

    typedef struct packed {
        logic [TREE_AW-1:0] p;
        logic [REL_W-1:0]   l;
        logic [REL_W-1:0]   r;
    } stk_ent_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PL_POP,
        ST_PU_RD,
        ST_PU_CHK,
        ST_PU_EVAL,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_EVAL,
        ST_RESULT
    } state_t;

endpackage
`default_nettype wire

// ----- sv/lcst_ram.sv -----
// Simple dual-port synchronous RAM, one write port, one registered read port.
`default_nettype none
module lcst_ram #(
    parameter int AW = 1,
    parameter int DW = 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/lcst_eval.sv -----
// Evaluates two lines k*x+b at one point, three-stage pipeline.
`default_nettype none
module lcst_eval (
    input  wire logic                                 aclk,
    input  wire logic signed [lcst_pkg::SLOPE_W-1:0] ka,
    input  wire logic signed [lcst_pkg::ICPT_W-1:0]  ba,
    input  wire logic signed [lcst_pkg::SLOPE_W-1:0] kb,
    input  wire logic signed [lcst_pkg::ICPT_W-1:0]  bb,
    input  wire logic signed [lcst_pkg::COORD_W-1:0] base_lo,
    input  wire logic        [lcst_pkg::REL_W-1:0]   rel,
    output logic signed      [lcst_pkg::VAL_W-1:0]   va,
    output logic signed      [lcst_pkg::VAL_W-1:0]   vb
);

    logic signed [lcst_pkg::ABS_W-1:0]   x_reg;
    logic signed [lcst_pkg::SLOPE_W-1:0] ka0_reg, kb0_reg;
    logic signed [lcst_pkg::ICPT_W-1:0]  ba0_reg, bb0_reg, ba1_reg, bb1_reg;
    logic signed [lcst_pkg::PROD_W-1:0]  pa_reg, pb_reg;

    always_ff @(posedge aclk) begin
        x_reg   <= lcst_pkg::ABS_W'(base_lo)
                 + $signed({{(lcst_pkg::ABS_W-lcst_pkg::REL_W){1'b0}}, rel});
        ka0_reg <= ka;
        kb0_reg <= kb;
        ba0_reg <= ba;
        bb0_reg <= bb;
        pa_reg  <= lcst_pkg::PROD_W'(ka0_reg) * lcst_pkg::PROD_W'(x_reg);
        pb_reg  <= lcst_pkg::PROD_W'(kb0_reg) * lcst_pkg::PROD_W'(x_reg);
        ba1_reg <= ba0_reg;
        bb1_reg <= bb0_reg;
        va      <= lcst_pkg::VAL_W'(pa_reg) + lcst_pkg::VAL_W'(ba1_reg);
        vb      <= lcst_pkg::VAL_W'(pb_reg) + lcst_pkg::VAL_W'(bb1_reg);
    end

endmodule
`default_nettype wire

// ----- sv/line_set_max_query_tree.sv -----
// Line-set maximum query tree: top level with node memory and control sequencer.
//
// Input stream (s_*): s_tuser carries the item kind (insert, query, clear),
// s_tdata the line and coordinates. Only a query produces a result on the
// m_* stream: m_tdata holds the maximum value, m_tuser the covered flag.
// Items are processed one at a time; s_tready is high while the block is idle.
// A query reads one tree node per level, up to 17 levels; each level
// takes a memory read, plus an evaluation when the node holds a line.
// An insert visits the nodes of the span decomposition and then descends
// below each covered node.
// Clear, reset and any configuration write run a clearing pass over all
// 262144 node entries, one per cycle, during which no item is accepted.
// A finished query result sits in the output register; the next item is
// accepted meanwhile, and a second result waits in the sequencer until the
// receiver takes the first one.
`default_nettype none
module line_set_max_query_tree (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] line_slope, [92:32] line_intercept, [116:93] seg_from,
    // [140:117] seg_to, [164:141] query_x, [167:165] zero
    input  wire logic [167:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [62:0] max_value, [63] zero
    output logic [63:0]       m_tdata,
    // [0] covered
    output logic              m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [23:0]  cfg_wdata
);

    localparam int AW = lcst_pkg::TREE_AW;
    localparam int RW = lcst_pkg::REL_W;
    localparam int CW = lcst_pkg::COORD_W;
    localparam int XW = lcst_pkg::ABS_W;

    logic signed [lcst_pkg::SLOPE_W-1:0] in_slope;
    logic signed [lcst_pkg::ICPT_W-1:0]  in_icpt;
    logic signed [CW-1:0] in_from, in_to, in_qx;

    assign in_slope = s_tdata[31:0];
    assign in_icpt  = s_tdata[92:32];
    assign in_from  = s_tdata[116:93];
    assign in_to    = s_tdata[140:117];
    assign in_qx    = s_tdata[164:141];

    lcst_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic signed [CW-1:0] cfg_low_reg, cfg_high_reg;
    logic signed [CW-1:0] base_reg;
    logic [RW-1:0]        last_reg;
    logic signed [XW-1:0] hi_reg;

    // range normalization
    logic signed [CW-1:0] rng_lo, rng_hi;
    logic [XW-1:0]        rng_diff;
    logic [RW-1:0]        rng_last;

    always_comb begin
        rng_lo   = (cfg_low_reg < cfg_high_reg) ? cfg_low_reg : cfg_high_reg;
        rng_hi   = (cfg_low_reg < cfg_high_reg) ? cfg_high_reg : cfg_low_reg;
        rng_diff = XW'(rng_hi) - XW'(rng_lo);
        if (rng_diff > XW'(lcst_pkg::DOMAIN_POINTS - 1)) begin
            rng_last = RW'(lcst_pkg::DOMAIN_POINTS - 1);
        end else begin
            rng_last = rng_diff[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_low_reg  <= '0;
            cfg_high_reg <= 24'sd65535;
        end else if (cfg_wr_en) begin
            if (cfg_index == lcst_pkg::CFG_RANGE_LOW) begin
                cfg_low_reg <= cfg_wdata;
            end else begin
                cfg_high_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= rng_lo;
        last_reg <= rng_last;
        hi_reg   <= XW'(rng_lo) + $signed({{(XW-RW){1'b0}}, rng_last});
    end

    // item registers
    logic signed [lcst_pkg::SLOPE_W-1:0] k_reg, k_next, pk_reg, pk_next, ok_reg, ok_next;
    logic signed [lcst_pkg::ICPT_W-1:0]  b_reg, b_next, pb_reg, pb_next, ob_reg, ob_next;
    logic [RW-1:0] x_reg, x_next, y_reg, y_next, qx_reg, qx_next;
    logic [AW-1:0] cur_p_reg, cur_p_next;
    logic [RW-1:0] cur_l_reg, cur_l_next, cur_r_reg, cur_r_next;
    logic [2:0]    ph_reg, ph_next;
    logic          swap_reg, swap_next, cl_reg, cl_next;
    logic signed [lcst_pkg::VAL_W-1:0] best_reg, best_next;
    logic          found_reg, found_next;

    lcst_pkg::stk_ent_t stk [lcst_pkg::STACK_DEPTH];
    logic [lcst_pkg::SP_W-1:0] sp_reg, sp_next;
    logic               stk_we0, stk_we1;
    logic [lcst_pkg::STK_AW-1:0] stk_idx0, stk_idx1;
    lcst_pkg::stk_ent_t stk_d0, stk_d1, stk_top;
    logic [lcst_pkg::SP_W-1:0] sp_dec;

    logic               m_valid_reg, m_valid_next;
    logic [lcst_pkg::OUT_W-1:0] m_value_reg, m_value_next;
    logic               m_cov_reg, m_cov_next;

    // memory
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    lcst_pkg::node_t wr_data, rd_node;
    logic [$bits(lcst_pkg::node_t)-1:0] rd_raw;

    lcst_ram #(
        .AW(AW),
        .DW($bits(lcst_pkg::node_t))
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_node = lcst_pkg::node_t'(rd_raw);

    // evaluator
    logic [RW-1:0] ev_rel;
    logic signed [lcst_pkg::VAL_W-1:0] va, vb;

    lcst_eval u_eval (
        .aclk    (aclk),
        .ka      (ok_reg),
        .ba      (ob_reg),
        .kb      (pk_reg),
        .bb      (pb_reg),
        .base_lo (base_reg),
        .rel     (ev_rel),
        .va      (va),
        .vb      (vb)
    );

    logic [RW-1:0] cur_mid, top_mid;
    logic [RW:0]   cur_sum, top_sum;
    logic          ev_lt, ev_gt, cr;
    logic          ins_skip, q_in;
    logic signed [XW-1:0] f_abs, t_abs, q_abs, b_abs, f_cl, t_cl;
    logic [XW-1:0] f_rel, t_rel, q_rel;

    assign sp_dec  = sp_reg - 1'b1;
    assign stk_top = stk[sp_dec[lcst_pkg::STK_AW-1:0]];
    assign cur_sum = {1'b0, cur_l_reg} + {1'b0, cur_r_reg};
    assign cur_mid = cur_sum[RW:1];
    assign top_sum = {1'b0, stk_top.l} + {1'b0, stk_top.r};
    assign top_mid = top_sum[RW:1];
    assign ev_lt   = va < vb;
    assign ev_gt   = va > vb;

    always_comb begin
        f_abs    = XW'(in_from);
        t_abs    = XW'(in_to);
        q_abs    = XW'(in_qx);
        b_abs    = XW'(base_reg);
        ins_skip = (t_abs < f_abs) || (t_abs < b_abs) || (f_abs > hi_reg);
        f_cl     = (f_abs < b_abs) ? b_abs : f_abs;
        t_cl     = (t_abs > hi_reg) ? hi_reg : t_abs;
        f_rel    = f_cl - b_abs;
        t_rel    = t_cl - b_abs;
        q_rel    = q_abs - b_abs;
        q_in     = (q_abs >= b_abs) && (q_abs <= hi_reg);
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        k_next = k_reg; b_next = b_reg;
        pk_next = pk_reg; pb_next = pb_reg;
        ok_next = ok_reg; ob_next = ob_reg;
        x_next = x_reg; y_next = y_reg; qx_next = qx_reg;
        cur_p_next = cur_p_reg; cur_l_next = cur_l_reg; cur_r_next = cur_r_reg;
        ph_next = ph_reg; swap_next = swap_reg; cl_next = cl_reg;
        best_next = best_reg; found_next = found_reg;
        sp_next = sp_reg;
        stk_we0 = 1'b0; stk_we1 = 1'b0;
        stk_idx0 = sp_dec[lcst_pkg::STK_AW-1:0];
        stk_idx1 = sp_reg[lcst_pkg::STK_AW-1:0];
        stk_d0 = '0; stk_d1 = '0;
        m_valid_next = m_valid_reg & ~m_tready;
        m_value_next = m_value_reg;
        m_cov_next   = m_cov_reg;
        wr_en = 1'b0; wr_addr = cur_p_reg; wr_data = '0;
        rd_en = 1'b0; rd_addr = cur_p_reg;
        s_tready = 1'b0;
        ev_rel = qx_reg;
        cr = 1'b0;

        unique case (state_reg)
            lcst_pkg::ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(lcst_pkg::TREE_DEPTH - 1)) begin
                    state_next = lcst_pkg::ST_IDLE;
                end
            end
            lcst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        lcst_pkg::KIND_INSERT: begin
                            if (!ins_skip) begin
                                k_next   = in_slope;
                                b_next   = in_icpt;
                                x_next   = f_rel[RW-1:0];
                                y_next   = t_rel[RW-1:0];
                                stk_we0  = 1'b1;
                                stk_idx0 = '0;
                                stk_d0   = '{p: AW'(1), l: '0, r: last_reg};
                                sp_next  = lcst_pkg::SP_W'(1);
                                state_next = lcst_pkg::ST_PL_POP;
                            end
                        end
                        lcst_pkg::KIND_QUERY: begin
                            best_next  = lcst_pkg::NONE_VALUE;
                            found_next = 1'b0;
                            qx_next    = q_rel[RW-1:0];
                            cur_p_next = AW'(1);
                            cur_l_next = '0;
                            cur_r_next = last_reg;
                            state_next = q_in ? lcst_pkg::ST_Q_RD : lcst_pkg::ST_RESULT;
                        end
                        lcst_pkg::KIND_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = lcst_pkg::ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lcst_pkg::ST_PL_POP: begin
                if (sp_reg == '0) begin
                    state_next = lcst_pkg::ST_IDLE;
                end else if (x_reg <= stk_top.l && stk_top.r <= y_reg) begin
                    cur_p_next = stk_top.p;
                    cur_l_next = stk_top.l;
                    cur_r_next = stk_top.r;
                    pk_next    = k_reg;
                    pb_next    = b_reg;
                    sp_next    = sp_dec;
                    state_next = lcst_pkg::ST_PU_RD;
                end else begin
                    // right child pending on the stack, left child on top
                    priority if (y_reg > top_mid && x_reg <= top_mid) begin
                        stk_we0 = 1'b1;
                        stk_d0  = '{p: {stk_top.p[AW-2:0], 1'b1},
                                    l: top_mid + 1'b1, r: stk_top.r};
                        stk_we1 = 1'b1;
                        stk_idx1 = sp_reg[lcst_pkg::STK_AW-1:0];
                        stk_d1  = '{p: {stk_top.p[AW-2:0], 1'b0},
                                    l: stk_top.l, r: top_mid};
                        sp_next = sp_reg + 1'b1;
                    end else if (y_reg > top_mid) begin
                        stk_we0 = 1'b1;
                        stk_d0  = '{p: {stk_top.p[AW-2:0], 1'b1},
                                    l: top_mid + 1'b1, r: stk_top.r};
                    end else if (x_reg <= top_mid) begin
                        stk_we0 = 1'b1;
                        stk_d0  = '{p: {stk_top.p[AW-2:0], 1'b0},
                                    l: stk_top.l, r: top_mid};
                    end else begin
                        sp_next = sp_dec;
                    end
                end
            end
            lcst_pkg::ST_PU_RD: begin
                rd_en      = 1'b1;
                state_next = lcst_pkg::ST_PU_CHK;
            end
            lcst_pkg::ST_PU_CHK: begin
                if (!rd_node.valid) begin
                    wr_en      = 1'b1;
                    wr_data    = '{valid: 1'b1, slope: pk_reg, intercept: pb_reg};
                    state_next = lcst_pkg::ST_PL_POP;
                end else begin
                    ok_next    = rd_node.slope;
                    ob_next    = rd_node.intercept;
                    ph_next    = '0;
                    state_next = lcst_pkg::ST_PU_EVAL;
                end
            end
            lcst_pkg::ST_PU_EVAL: begin
                // issue midpoint, left end, right end; results return through the evaluator pipeline
                unique case (ph_reg)
                    3'd0:    ev_rel = cur_mid;
                    3'd1:    ev_rel = cur_l_reg;
                    default: ev_rel = cur_r_reg;
                endcase
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd3) begin
                    swap_next = ev_lt;
                end
                if (ph_reg == 3'd4) begin
                    cl_next = swap_reg ? ev_gt : ev_lt;
                end
                if (ph_reg == 3'd5) begin
                    cr = swap_reg ? ev_gt : ev_lt;
                    if (swap_reg) begin
                        wr_en   = 1'b1;
                        wr_data = '{valid: 1'b1, slope: pk_reg, intercept: pb_reg};
                        pk_next = ok_reg;
                        pb_next = ob_reg;
                    end
                    priority if (cur_l_reg == cur_r_reg) begin
                        state_next = lcst_pkg::ST_PL_POP;
                    end else if (cl_reg) begin
                        cur_p_next = {cur_p_reg[AW-2:0], 1'b0};
                        cur_r_next = cur_mid;
                        state_next = lcst_pkg::ST_PU_RD;
                    end else if (cr) begin
                        cur_p_next = {cur_p_reg[AW-2:0], 1'b1};
                        cur_l_next = cur_mid + 1'b1;
                        state_next = lcst_pkg::ST_PU_RD;
                    end else begin
                        state_next = lcst_pkg::ST_PL_POP;
                    end
                end
            end
            lcst_pkg::ST_Q_RD: begin
                rd_en      = 1'b1;
                state_next = lcst_pkg::ST_Q_CHK;
            end
            lcst_pkg::ST_Q_CHK, lcst_pkg::ST_Q_EVAL: begin
                logic step;
                step = 1'b0;
                if (state_reg == lcst_pkg::ST_Q_CHK) begin
                    if (rd_node.valid) begin
                        ok_next    = rd_node.slope;
                        ob_next    = rd_node.intercept;
                        ph_next    = '0;
                        state_next = lcst_pkg::ST_Q_EVAL;
                    end else begin
                        step = 1'b1;
                    end
                end else begin
                    ph_next = ph_reg + 1'b1;
                    if (ph_reg == 3'd3) begin
                        if (!found_reg || va > best_reg) begin
                            best_next = va;
                        end
                        found_next = 1'b1;
                        step = 1'b1;
                    end
                end
                if (step) begin
                    priority if (cur_l_reg == cur_r_reg) begin
                        state_next = lcst_pkg::ST_RESULT;
                    end else if (qx_reg <= cur_mid) begin
                        cur_p_next = {cur_p_reg[AW-2:0], 1'b0};
                        cur_r_next = cur_mid;
                        state_next = lcst_pkg::ST_Q_RD;
                    end else begin
                        cur_p_next = {cur_p_reg[AW-2:0], 1'b1};
                        cur_l_next = cur_mid + 1'b1;
                        state_next = lcst_pkg::ST_Q_RD;
                    end
                end
            end
            lcst_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = best_reg[lcst_pkg::OUT_W-1:0];
                    m_cov_next   = found_reg;
                    state_next   = lcst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcst_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            clr_cnt_next = '0;
            state_next   = lcst_pkg::ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcst_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next; b_reg <= b_next;
        pk_reg <= pk_next; pb_reg <= pb_next;
        ok_reg <= ok_next; ob_reg <= ob_next;
        x_reg <= x_next; y_reg <= y_next; qx_reg <= qx_next;
        cur_p_reg <= cur_p_next; cur_l_reg <= cur_l_next; cur_r_reg <= cur_r_next;
        ph_reg <= ph_next; swap_reg <= swap_next; cl_reg <= cl_next;
        best_reg <= best_next; found_reg <= found_next;
        m_value_reg <= m_value_next;
        m_cov_reg   <= m_cov_next;
        if (stk_we0) begin
            stk[stk_idx0] <= stk_d0;
        end
        if (stk_we1) begin
            stk[stk_idx1] <= stk_d1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_value_reg};
    assign m_tuser  = m_cov_reg;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for line_set_max_query_tree: directed and random inserts, queries and range changes.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES       = 4 * lcst_pkg::DOMAIN_POINTS;
    localparam int STALL_LIMIT = 1200000;
    localparam longint NONE_MAG = 64'sh3f3f3f3f3f3f3f3f;

    typedef struct packed {
        logic [62:0] max_value;
        logic        covered;
    } peak_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = lcst_pkg::KIND_INSERT;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = lcst_pkg::CFG_RANGE_LOW;
    logic [23:0]  cfg_wdata = '0;

    line_set_max_query_tree dut (.*);

    always #5 aclk = ~aclk;

    // tree mirror
    bit                  tree_has [NODES];
    longint              tree_k   [NODES];
    longint              tree_b   [NODES];
    logic signed [23:0]  reg_low  = 24'sd0;
    logic signed [23:0]  reg_high = 24'sd65535;
    longint              base_x;
    int                  npts;

    peak_t  pending_peaks[$];
    int     errors = 0;
    bit     calm   = 1'b0;
    int     m_hold = 0;
    int     quiet  = 0;

    function automatic void clear_tree();
        for (int i = 0; i < NODES; i++) tree_has[i] = 1'b0;
    endfunction

    function automatic void apply_range();
        longint a, c, lo, hi;
        a = reg_low;
        c = reg_high;
        lo = (a < c) ? a : c;
        hi = (a < c) ? c : a;
        if (hi - lo + 1 > lcst_pkg::DOMAIN_POINTS) hi = lo + lcst_pkg::DOMAIN_POINTS - 1;
        base_x = lo;
        npts = int'(hi - lo + 1);
        clear_tree();
    endfunction

    // Keep the midpoint winner, send the loser down where it still wins.
    function automatic void settle_line(longint k, longint b, int p, int l, int r);
        int mid;
        longint xm, xl, xr, t;
        if (p >= NODES) return;
        if (!tree_has[p]) begin
            tree_has[p] = 1'b1;
            tree_k[p] = k;
            tree_b[p] = b;
            return;
        end
        mid = (l + r) >> 1;
        xm = base_x + mid;
        if (tree_k[p] * xm + tree_b[p] < k * xm + b) begin
            t = tree_k[p]; tree_k[p] = k; k = t;
            t = tree_b[p]; tree_b[p] = b; b = t;
        end
        if (l == r) return;
        xl = base_x + l;
        xr = base_x + r;
        if (tree_k[p] * xl + tree_b[p] < k * xl + b) settle_line(k, b, 2 * p, l, mid);
        if (tree_k[p] * xr + tree_b[p] < k * xr + b) settle_line(k, b, 2 * p + 1, mid + 1, r);
    endfunction

    function automatic void cover_span(longint k, longint b, int x, int y,
                                       int p, int l, int r);
        int mid;
        if (p >= NODES) return;
        if (x <= l && r <= y) begin
            settle_line(k, b, p, l, r);
            return;
        end
        mid = (l + r) >> 1;
        if (x <= mid) cover_span(k, b, x, y, 2 * p, l, mid);
        if (y > mid) cover_span(k, b, x, y, 2 * p + 1, mid + 1, r);
    endfunction

    function automatic void insert_line(longint k, longint b, longint f, longint t);
        longint hi;
        hi = base_x + npts - 1;
        if (t < f || t < base_x || f > hi) return;
        if (f < base_x) f = base_x;
        if (t > hi) t = hi;
        cover_span(k, b, int'(f - base_x), int'(t - base_x), 1, 0, npts - 1);
    endfunction

    function automatic peak_t peak_at(longint x);
        peak_t  res;
        longint best, v;
        bit     found;
        int     u, p, l, r, mid;
        best = -NONE_MAG;
        found = 1'b0;
        if (x >= base_x && x <= base_x + npts - 1) begin
            u = int'(x - base_x);
            p = 1; l = 0; r = npts - 1;
            while (p < NODES) begin
                if (tree_has[p]) begin
                    v = tree_k[p] * x + tree_b[p];
                    if (!found || v > best) best = v;
                    found = 1'b1;
                end
                if (l == r) break;
                mid = (l + r) >> 1;
                if (u <= mid) begin
                    p = 2 * p; r = mid;
                end else begin
                    p = 2 * p + 1; l = mid + 1;
                end
            end
        end
        res.max_value = best[62:0];
        res.covered = found;
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [1:0] kind, logic signed [31:0] k, logic signed [60:0] b,
                             logic signed [23:0] f, logic signed [23:0] t,
                             logic signed [23:0] qx);
        int g;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, qx, t, f, b, k};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        case (kind)
            lcst_pkg::KIND_INSERT: insert_line(k, b, f, t);
            lcst_pkg::KIND_QUERY:  pending_peaks.push_back(peak_at(qx));
            lcst_pkg::KIND_CLEAR:  clear_tree();
            default: ;
        endcase
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic query(logic signed [23:0] qx);
        send_item(lcst_pkg::KIND_QUERY, '0, '0, '0, '0, qx);
    endtask

    task automatic insert(logic signed [31:0] k, logic signed [60:0] b,
                          logic signed [23:0] f, logic signed [23:0] t);
        send_item(lcst_pkg::KIND_INSERT, k, b, f, t, '0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_peaks.size() != 0) @(posedge aclk);
        // inserts give no result; let any descent finish
        repeat (3000) @(posedge aclk);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_range(logic idx, logic signed [23:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lcst_pkg::CFG_RANGE_LOW) reg_low = val;
        else reg_high = val;
        apply_range();
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic signed [23:0] pick_x();
        if ($urandom_range(0, 9) == 0) return 24'($urandom);
        return 24'(base_x + $urandom_range(0, npts - 1));
    endfunction

    task automatic test_directed();
        longint lo, hi;
        lo = base_x;
        hi = base_x + npts - 1;
        query(24'(lo));                                         // empty tree
        send_item(2'd3, 32'sd5, 61'sd5, 24'(lo), 24'(hi), 24'(lo)); // unused kind
        insert(32'sh7fffffff, 61'h0fffffffffffffff, 24'(lo), 24'(hi));
        insert(32'sh80000000, 61'h1000000000000000, 24'(lo), 24'(hi));
        insert(32'sd3, 61'sd100, 24'(lo + 10), 24'(lo + 5));     // empty span
        insert(32'sd1, 61'sd7, 24'sh800000, 24'(lo - 1));       // below range when lo - 1 does not wrap
        insert(32'sd0, 61'sd0, 24'(lo + 3), 24'(lo + 3));
        insert(32'sd0, 61'sd0, 24'(lo + 3), 24'(lo + 3));       // tie at midpoint
        insert(-32'sd4, 61'sd50, 24'sh800000, 24'sh7fffff);     // clipped span
        query(24'(lo));
        query(24'(hi));
        query(24'(lo + 3));
        query(24'(lo - 1));
        query(24'(hi + 1));
        query(24'sh800000);
        query(24'sh7fffff);
        send_item(lcst_pkg::KIND_CLEAR, '0, '0, '0, '0, '0);
        query(24'(lo + 3));
        insert(-32'sd1, -61'sd1, 24'(lo), 24'(hi));
        query(24'(hi));
    endtask

    task automatic test_random(int n);
        logic signed [31:0] k;
        logic signed [60:0] b;
        logic signed [23:0] f, t, x;
        logic [63:0]        w;
        int                 r;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            f = pick_x();
            t = pick_x();
            if ($urandom_range(0, 3) != 0 && t < f) {f, t} = {t, f};
            if ($urandom_range(0, 2) == 0) t = 24'(f + $urandom_range(0, 3));
            if ($urandom_range(0, 9) < 7) k = $signed($urandom_range(0, 200)) - 100;
            else k = $urandom;
            w = {$urandom, $urandom};
            if ($urandom_range(0, 9) < 7) b = 61'($signed(w[20:0]));
            else b = w[60:0];
            x = pick_x();
            if (r < 45) insert(k, b, f, t);
            else if (r < 95) query(x);
            else send_item(2'd3, k, b, f, t, x);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        apply_range();
        do @(posedge aclk); while (!s_tready);
        test_directed();
        test_random(650);
        write_range(lcst_pkg::CFG_RANGE_LOW, 24'sh800000);
        test_random(450);
        write_range(lcst_pkg::CFG_RANGE_HIGH, -24'sd8388601);
        test_directed();
        test_random(400);
        write_range(lcst_pkg::CFG_RANGE_LOW, 24'sh7fffff);
        test_random(400);
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (m_hold > 0) begin
            m_hold <= m_hold - 1;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 3) m_hold <= $urandom_range(10, 40);
            m_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // result check: each transaction against the oldest expectation
    always @(posedge aclk) begin
        peak_t e;
        if (m_tvalid && m_tready) begin
            if (pending_peaks.size() == 0) begin
                $error("unexpected result: max_value %0h covered %0b", m_tdata[62:0], m_tuser);
                errors++;
            end else begin
                e = pending_peaks.pop_front();
                if (m_tdata[62:0] !== e.max_value) begin
                    $error("max_value expected %0h actual %0h", e.max_value, m_tdata[62:0]);
                    errors++;
                end
                if (m_tuser !== e.covered) begin
                    $error("covered expected %0b actual %0b", e.covered, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
`default_nettype wire
